// ----- sv/six_axis_serial_packet_decoder_top_assert.svh -----
// ----------------------------------------------------------------------------
// Six-axis serial packet decoder: assertion macros
// Shorthand for the clocked, reset-gated checks used in the decoder.
// ----------------------------------------------------------------------------
`ifndef SIX_AXIS_SERIAL_PACKET_DECODER_TOP_ASSERT_SVH
`define SIX_AXIS_SERIAL_PACKET_DECODER_TOP_ASSERT_SVH

// Same-cycle implication
`define SASPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SASPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/saspd_pkg.sv -----
// ----------------------------------------------------------------------------
// saspd_pkg
// Constants, codes and the payload code table of the six-axis packet decoder.
// ----------------------------------------------------------------------------
package saspd_pkg;

  // Packet buffer geometry
  localparam int unsigned BufDepth = 64;
  localparam int unsigned AddrW    = $clog2(BufDepth);
  localparam int unsigned CntW     = $clog2(BufDepth + 1);

  // Widest payload is the axis packet: 24 nibbles
  localparam int unsigned AxisNibbles = 24;
  localparam int unsigned NibW        = 4 * AxisNibbles;
  localparam int unsigned IdxW        = $clog2(AxisNibbles + 2);
  localparam logic [2:0]  LastAxis    = 3'd5;

  // Special bytes and packet letters
  localparam logic [7:0] ByteCr    = 8'h0D;
  localparam logic [7:0] LetAxis   = 8'h64; // d
  localparam logic [7:0] LetError  = 8'h65; // e
  localparam logic [7:0] LetButton = 8'h6B; // k
  localparam logic [7:0] LetMode   = 8'h6D; // m
  localparam logic [7:0] LetNull   = 8'h6E; // n
  localparam logic [7:0] LetRate   = 8'h70; // p
  localparam logic [7:0] LetSens   = 8'h71; // q
  localparam logic [7:0] LetVer    = 8'h76; // v
  localparam logic [7:0] LetZero   = 8'h7A; // z

  // Result kinds
  typedef enum logic [2:0] {
    KIND_AXIS   = 3'd0,
    KIND_BUTTON = 3'd1,
    KIND_ERROR  = 3'd2,
    KIND_ACK    = 3'd3,
    KIND_REJECT = 3'd4
  } kind_e;

  // Error report kinds
  localparam logic [1:0] ErrCommand = 2'd0;
  localparam logic [1:0] ErrFraming = 2'd1;
  localparam logic [1:0] ErrUnknown = 2'd2;
  localparam logic [3:0] ErrNibCmd  = 4'd1;
  localparam logic [3:0] ErrNibFrm  = 4'd2;

  // Register map
  localparam logic RegReportsEn = 1'b0;

  // Nibble encoding: byte must equal the table entry selected by its low nibble
  function automatic logic [7:0] code_of(input logic [3:0] nib);
    logic [7:0] c;
    case (nib)
      4'h0:    c = 8'h30; // 0
      4'h1:    c = 8'h41; // A
      4'h2:    c = 8'h42; // B
      4'h3:    c = 8'h33; // 3
      4'h4:    c = 8'h44; // D
      4'h5:    c = 8'h35; // 5
      4'h6:    c = 8'h36; // 6
      4'h7:    c = 8'h47; // G
      4'h8:    c = 8'h48; // H
      4'h9:    c = 8'h39; // 9
      4'hA:    c = 8'h3A; // :
      4'hB:    c = 8'h4B; // K
      4'hC:    c = 8'h3C; // <
      4'hD:    c = 8'h4D; // M
      4'hE:    c = 8'h4E; // N
      default: c = 8'h3F; // ?
    endcase
    return c;
  endfunction

endpackage

// ----- sv/six_axis_serial_packet_decoder_top.sv -----
// ----------------------------------------------------------------------------
// six_axis_serial_packet_decoder_top
// Buffers received serial bytes and decodes each carriage-return framed
// packet into axis, button, error, acknowledge or rejected results.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | to block  | in_valid_i / in_stall_o | rx_byte_i
//  out     | from block| out_valid_o/out_stall_i | kind_o .. last_o
//  cfg     | to block  | APB psel/penable/pready | reports_enabled at address 0
//
//  Data bytes are accepted while in_stall_o is low and, up to the buffer depth,
//  are written to the packet memory. A carriage return on a checked packet
//  scans the payload through the single memory read port and table checker,
//  then loads one result per cycle while out_stall_i is low.
//  Unchecked, unknown or wrong-length packets skip the scan.
//  in_stall_o is high from a carriage return until the last result is loaded.
//  The packet memory has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "six_axis_serial_packet_decoder_top_assert.svh"

module six_axis_serial_packet_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input bytes
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  ack_type_o,
  output logic [2:0]  axis_index_o,
  output logic signed [15:0] axis_value_o,
  output logic [8:0]  button_mask_o,
  output logic [1:0]  error_kind_o,
  output logic [7:0]  failing_command_o,
  output logic        last_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [saspd_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [7:0]                 letter_q, letter_d;
  logic [saspd_pkg::IdxW-1:0] iss_q, iss_d, rcv_q, rcv_d, need_q, need_d;
  logic                       pend_q, pend_d;
  logic                       ok_q, ok_d;
  logic [saspd_pkg::NibW-1:0] nib_q, nib_d;
  saspd_pkg::kind_e           rkind_q, rkind_d;
  logic [2:0]                 ax_q, ax_d;
  logic                       en_q;

  logic [7:0] mem [saspd_pkg::BufDepth];
  logic [7:0] rdata_q;
  logic       wr_en, rd_en;

  logic in_acc, is_cr, out_free, load;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == saspd_pkg::RegReportsEn) begin
      en_q <= pwdata[0];
    end
  end
  assign prdata = (paddr[2] == saspd_pkg::RegReportsEn) ? {31'd0, en_q} : 32'd0;

  // Input handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_cr      = (rx_byte_i == saspd_pkg::ByteCr);
  assign wr_en      = in_acc && !is_cr && (cnt_q < saspd_pkg::CntW'(saspd_pkg::BufDepth));
  assign rd_en      = (state_q == ST_SCAN) && (iss_q <= need_q);

  // Packet memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[saspd_pkg::AddrW-1:0]] <= rx_byte_i;
    end
    if (rd_en) begin
      rdata_q <= mem[saspd_pkg::AddrW'(iss_q)];
    end
  end

  // Result assembly from the nibble register
  saspd_pkg::kind_e res_kind;
  logic [7:0]  res_ack;
  logic [2:0]  res_idx;
  logic [15:0] res_val;
  logic [8:0]  res_btn;
  logic [1:0]  res_err;
  logic [7:0]  res_fail;
  logic        res_last;
  logic [3:0]  n1, n2, n3;

  assign n1 = nib_q[11:8];
  assign n2 = nib_q[7:4];
  assign n3 = nib_q[3:0];

  always_comb begin
    res_kind = ok_q ? rkind_q : saspd_pkg::KIND_REJECT;
    res_ack  = (res_kind == saspd_pkg::KIND_REJECT) ? 8'd0 : letter_q;
    res_idx  = 3'd0;
    res_val  = 16'd0;
    res_btn  = 9'd0;
    res_err  = 2'd0;
    res_fail = 8'd0;
    res_last = 1'b1;
    case (res_kind)
      saspd_pkg::KIND_AXIS: begin
        // adding 32768 modulo 2^16 flips the top bit
        res_idx  = ax_q;
        res_val  = {~nib_q[saspd_pkg::NibW-1], nib_q[saspd_pkg::NibW-2 -: 15]};
        res_last = (ax_q == saspd_pkg::LastAxis);
      end
      saspd_pkg::KIND_BUTTON: begin
        res_btn = {n2, 5'd0} | {4'd0, n1, 1'b0} | {5'd0, n3};
      end
      saspd_pkg::KIND_ERROR: begin
        if (n1 == saspd_pkg::ErrNibCmd) begin
          res_err  = saspd_pkg::ErrCommand;
          res_fail = {n3, n2};
        end else if (n1 == saspd_pkg::ErrNibFrm) begin
          res_err = saspd_pkg::ErrFraming;
        end else begin
          res_err = saspd_pkg::ErrUnknown;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_free = !out_valid_o || !out_stall_i;
  assign load     = (state_q == ST_EMIT) && out_free;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    letter_d = letter_q;
    iss_d    = iss_q;
    rcv_d    = rcv_q;
    need_d   = need_q;
    pend_d   = 1'b0;
    ok_d     = ok_q;
    nib_d    = nib_q;
    rkind_d  = rkind_q;
    ax_d     = ax_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && !is_cr) begin
          if (wr_en) begin
            cnt_d = cnt_q + 1'b1;
            if (cnt_q == '0) begin
              letter_d = rx_byte_i;
            end
          end
        end else if (in_acc && is_cr) begin
          cnt_d = '0;
          iss_d = saspd_pkg::IdxW'(1);
          rcv_d = '0;
          ok_d  = 1'b1;
          ax_d  = 3'd0;
          if (cnt_q != '0) begin
            state_d = ST_SCAN;
            rkind_d = saspd_pkg::KIND_REJECT;
            need_d  = '0;
            // required payload length (letter excluded) per packet type
            case (letter_q)
              saspd_pkg::LetAxis: begin
                rkind_d = saspd_pkg::KIND_AXIS;
                need_d  = saspd_pkg::IdxW'(saspd_pkg::AxisNibbles);
              end
              saspd_pkg::LetError: begin
                rkind_d = saspd_pkg::KIND_ERROR;
                need_d  = saspd_pkg::IdxW'(3);
              end
              saspd_pkg::LetButton: begin
                rkind_d = saspd_pkg::KIND_BUTTON;
                need_d  = saspd_pkg::IdxW'(3);
              end
              saspd_pkg::LetMode, saspd_pkg::LetNull: begin
                rkind_d = saspd_pkg::KIND_ACK;
                need_d  = saspd_pkg::IdxW'(1);
              end
              saspd_pkg::LetRate, saspd_pkg::LetSens: begin
                rkind_d = saspd_pkg::KIND_ACK;
                need_d  = saspd_pkg::IdxW'(2);
              end
              saspd_pkg::LetVer, saspd_pkg::LetZero: begin
                rkind_d = saspd_pkg::KIND_ACK;
                state_d = ST_EMIT;
              end
              default: begin
                state_d = ST_EMIT;
              end
            endcase
            // wrong length, or reports off for axis and button: reject without scan
            if (state_d == ST_SCAN) begin
              if (cnt_q != saspd_pkg::CntW'(need_d) + 1'b1) begin
                rkind_d = saspd_pkg::KIND_REJECT;
                state_d = ST_EMIT;
              end else if (!en_q && (rkind_d == saspd_pkg::KIND_AXIS ||
                                     rkind_d == saspd_pkg::KIND_BUTTON)) begin
                rkind_d = saspd_pkg::KIND_REJECT;
                state_d = ST_EMIT;
              end
            end
          end
        end
      end
      ST_SCAN: begin
        // issue one read per cycle, check the byte from the registered read port
        if (rd_en) begin
          iss_d  = iss_q + 1'b1;
          pend_d = 1'b1;
        end
        if (pend_q) begin
          rcv_d = rcv_q + 1'b1;
          nib_d = {nib_q[saspd_pkg::NibW-5:0], rdata_q[3:0]};
          if (rdata_q != saspd_pkg::code_of(rdata_q[3:0])) begin
            ok_d = 1'b0;
          end
          if (rcv_d == need_q) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (load) begin
          if (res_last) begin
            state_d = ST_IDLE;
          end else begin
            ax_d  = ax_q + 1'b1;
            nib_d = nib_q << 16;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      iss_q   <= '0;
      rcv_q   <= '0;
      need_q  <= '0;
      pend_q  <= 1'b0;
      ok_q    <= 1'b1;
      rkind_q <= saspd_pkg::KIND_REJECT;
      ax_q    <= 3'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      iss_q   <= iss_d;
      rcv_q   <= rcv_d;
      need_q  <= need_d;
      pend_q  <= pend_d;
      ok_q    <= ok_d;
      rkind_q <= rkind_d;
      ax_q    <= ax_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    letter_q <= letter_d;
    nib_q    <= nib_d;
  end

  // Output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  logic [2:0]  kind_q;
  logic [7:0]  ack_q;
  logic [2:0]  idx_q;
  logic [15:0] val_q;
  logic [8:0]  btn_q;
  logic [1:0]  err_q;
  logic [7:0]  fail_q;
  logic        last_q;
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= res_kind;
      ack_q  <= res_ack;
      idx_q  <= res_idx;
      val_q  <= res_val;
      btn_q  <= res_btn;
      err_q  <= res_err;
      fail_q <= res_fail;
      last_q <= res_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign ack_type_o        = ack_q;
  assign axis_index_o      = idx_q;
  assign axis_value_o      = val_q;
  assign button_mask_o     = btn_q;
  assign error_kind_o      = err_q;
  assign failing_command_o = fail_q;
  assign last_o            = last_q;

  // Assertions
  `SASPD_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1,
    cnt_q <= saspd_pkg::CntW'(saspd_pkg::BufDepth), "byte count beyond buffer depth")
  `SASPD_ASSERT_NOW(a_scan_bound, clk_i, rst_ni, state_q == ST_SCAN,
    rcv_q < need_q, "scan ran past payload length")
  `SASPD_ASSERT_NOW(a_single_last, clk_i, rst_ni,
    out_valid_o && kind_o != saspd_pkg::KIND_AXIS, last_o, "single result without last")
  `SASPD_ASSERT_NEXT(a_emit_done, clk_i, rst_ni, load && res_last,
    state_q == ST_IDLE && out_valid_o && last_o, "last result did not end the packet")

endmodule

// ----- test/six_axis_serial_packet_decoder_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Six-axis serial packet decoder: block-level test
// Feeds received bytes through the request channel and predicts every decoded
// result from a local copy of the packet buffer and the reports-enable
// register. Directed packets cover each packet type, the rejection rules,
// buffer overflow and a long output hold-off. Random well-formed packets,
// broken packets and noise follow, with random idling on both sides.
// ----------------------------------------------------------------------------
module six_axis_serial_packet_decoder_top_test;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned PhaseBytes   = 8;
  localparam int unsigned MaxShown     = 10;
  localparam logic [2:0]  ReportsEnAddr = {saspd_pkg::RegReportsEn, 2'b00};
  localparam logic [2:0]  SpareAddr     = 3'd4;
  // Payload byte for each nibble value, nibble 0 in the top byte
  localparam logic [127:0] CodeTable    = "0AB3D56GH9:K<MN?";

  // Ways of spoiling a coded packet
  typedef enum int unsigned {
    FLAW_NONE,
    FLAW_SHORT,
    FLAW_LONG,
    FLAW_CORRUPT
  } flaw_e;

  typedef struct packed {
    saspd_pkg::kind_e   kind;
    logic [7:0]         ack_type;
    logic [2:0]         axis_index;
    logic signed [15:0] axis_value;
    logic [8:0]         button_mask;
    logic [1:0]         error_kind;
    logic [7:0]         failing_command;
    logic               last;
  } report_t;

  logic               clk_i;
  logic               rst_ni     = 1'b0;
  logic               in_valid   = 1'b0;
  logic [7:0]         rx_byte    = 8'h00;
  logic               out_stall  = 1'b0;
  logic               psel       = 1'b0;
  logic               penable    = 1'b0;
  logic               pwrite     = 1'b0;
  logic [2:0]         paddr      = 3'd0;
  logic [31:0]        pwdata     = 32'd0;
  logic               in_stall;
  logic               out_valid;
  logic [2:0]         kind;
  logic [7:0]         ack_type;
  logic [2:0]         axis_index;
  logic signed [15:0] axis_value;
  logic [8:0]         button_mask;
  logic [1:0]         error_kind;
  logic [7:0]         failing_command;
  logic               last;
  logic [31:0]        prdata;
  logic               pready;

  // Local copy of the decoder state
  logic [7:0]   pkt_mem [saspd_pkg::BufDepth];
  int unsigned  pkt_len    = 0;
  logic         reports_en = 1'b1;
  report_t      expected_reports [$];

  int unsigned  mismatch_count = 0;
  int unsigned  bytes_sent     = 0;
  int unsigned  hold_cycles    = 0;
  int unsigned  cycle_count    = 0;
  bit           src_idle_on    = 1'b0;
  bit           snk_idle_on    = 1'b0;

  six_axis_serial_packet_decoder_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .rx_byte_i         (rx_byte),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .kind_o            (kind),
    .ack_type_o        (ack_type),
    .axis_index_o      (axis_index),
    .axis_value_o      (axis_value),
    .button_mask_o     (button_mask),
    .error_kind_o      (error_kind),
    .failing_command_o (failing_command),
    .last_o            (last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] enc(input logic [3:0] n);
    return CodeTable[127 - 8 * n -: 8];
  endfunction

  function automatic logic [3:0] nib(input int unsigned i);
    return pkt_mem[i][3:0];
  endfunction

  // Payload bytes 1..n must each be the code of their own low nibble
  function automatic bit payload_ok(input int unsigned n);
    int unsigned i;
    for (i = 1; i <= n; i++) begin
      if (pkt_mem[i] != enc(pkt_mem[i][3:0])) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic decode_packet();
    report_t     r;
    logic [7:0]  letter;
    int unsigned i;
    bit          ok;
    letter = pkt_mem[0];
    ok = 1'b0;
    r = '0;
    r.ack_type = letter;
    r.last = 1'b1;
    case (letter)
      saspd_pkg::LetAxis: begin
        if (pkt_len == 25 && payload_ok(24) && reports_en) begin
          for (i = 0; i < 6; i++) begin
            r.kind = saspd_pkg::KIND_AXIS;
            r.axis_index = 3'(i);
            r.axis_value = {nib(4 * i + 1), nib(4 * i + 2), nib(4 * i + 3),
                            nib(4 * i + 4)} ^ 16'h8000;
            r.last = (i == 5);
            expected_reports.push_back(r);
          end
          ok = 1'b1;
        end
      end
      saspd_pkg::LetError: begin
        if (pkt_len == 4 && payload_ok(3)) begin
          r.kind = saspd_pkg::KIND_ERROR;
          if (nib(1) == saspd_pkg::ErrNibCmd) begin
            r.error_kind = saspd_pkg::ErrCommand;
            r.failing_command = {nib(3), nib(2)};
          end else if (nib(1) == saspd_pkg::ErrNibFrm) begin
            r.error_kind = saspd_pkg::ErrFraming;
          end else begin
            r.error_kind = saspd_pkg::ErrUnknown;
          end
          expected_reports.push_back(r);
          ok = 1'b1;
        end
      end
      saspd_pkg::LetButton: begin
        if (pkt_len == 4 && payload_ok(3) && reports_en) begin
          r.kind = saspd_pkg::KIND_BUTTON;
          r.button_mask = (9'(nib(1)) << 1) | (9'(nib(2)) << 5) | 9'(nib(3));
          expected_reports.push_back(r);
          ok = 1'b1;
        end
      end
      saspd_pkg::LetMode, saspd_pkg::LetNull: begin
        if (pkt_len == 2 && payload_ok(1)) begin
          r.kind = saspd_pkg::KIND_ACK;
          expected_reports.push_back(r);
          ok = 1'b1;
        end
      end
      saspd_pkg::LetRate, saspd_pkg::LetSens: begin
        if (pkt_len == 3 && payload_ok(2)) begin
          r.kind = saspd_pkg::KIND_ACK;
          expected_reports.push_back(r);
          ok = 1'b1;
        end
      end
      saspd_pkg::LetVer, saspd_pkg::LetZero: begin
        r.kind = saspd_pkg::KIND_ACK;
        expected_reports.push_back(r);
        ok = 1'b1;
      end
      default: ok = 1'b0;
    endcase
    // Anything that failed its checks, or an unknown letter
    if (!ok) begin
      r = '0;
      r.kind = saspd_pkg::KIND_REJECT;
      r.last = 1'b1;
      expected_reports.push_back(r);
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    if (b == saspd_pkg::ByteCr) begin
      if (pkt_len != 0) decode_packet();
      pkt_len = 0;
    end else if (pkt_len < saspd_pkg::BufDepth) begin
      pkt_mem[pkt_len] = b;
      pkt_len++;
    end
  endtask

  // ----------------------------------------------------------------- checking

  function automatic string show(input report_t r);
    return $sformatf("kind=%0d ack=%02h idx=%0d val=%0d btn=%03h err=%0d cmd=%02h last=%0b",
                     r.kind, r.ack_type, r.axis_index, r.axis_value, r.button_mask,
                     r.error_kind, r.failing_command, r.last);
  endfunction

  task automatic report_mismatch(input string what, input string want, input string got);
    if (mismatch_count < MaxShown)
      $display("%0t %s\n  expected: %s\n  actual:   %s", $realtime, what, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : check_reports
    report_t got;
    report_t want;
    if (rst_ni && out_valid && !out_stall) begin
      got = {saspd_pkg::kind_e'(kind), ack_type, axis_index, axis_value, button_mask,
             error_kind, failing_command, last};
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected result", "none", show(got));
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) report_mismatch("result mismatch", show(want), show(got));
      end
    end
  end

  // Receiver: long hold-off on request, else random stall bursts
  always begin : receiver
    @(negedge clk_i);
    if (hold_cycles != 0) begin
      out_stall <= 1'b1;
      repeat (hold_cycles) @(negedge clk_i);
      hold_cycles = 0;
      out_stall <= 1'b0;
    end else if (snk_idle_on && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
      out_stall <= 1'b0;
    end
  end

  // ----------------------------------------------------------------- stimulus

  // Entered and left at a falling edge; valid stays high after the request
  task automatic send_byte(input logic [7:0] b);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (in_stall);
    absorb_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Letter, coded payload (nibble k taken LSB first from nibs), carriage return
  task automatic send_coded(input logic [7:0] letter, input int unsigned n_nib,
                            input logic [95:0] nibs, input flaw_e flaw);
    int unsigned count;
    int unsigned bad_pos;
    int unsigned k;
    logic [7:0]  b;
    count = n_nib;
    if (flaw == FLAW_SHORT && count != 0) count--;
    if (flaw == FLAW_LONG) count++;
    bad_pos = (flaw == FLAW_CORRUPT) ? $urandom_range(0, count) : count + 1;
    send_byte(bad_pos == 0 ? 8'($urandom_range(0, 255)) : letter);
    for (k = 1; k <= count; k++) begin
      if (k == bad_pos) b = 8'($urandom_range(0, 255));
      else b = enc(nibs[4 * ((k - 1) % 24) +: 4]);
      send_byte(b);
    end
    send_byte(saspd_pkg::ByteCr);
  endtask

  // Sender pauses until every result is back, then lets the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Register write, then read back the reports-enable register
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ReportsEnAddr) reports_en = value[0];
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ReportsEnAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {31'd0, reports_en})
      report_mismatch("register read-back", $sformatf("%08h", {31'd0, reports_en}),
                      $sformatf("%08h", prdata));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_random_packet();
    logic [95:0] nibs;
    logic [7:0]  letter;
    flaw_e       flaw;
    int unsigned k;
    nibs = {$urandom, $urandom, $urandom};
    flaw = ($urandom_range(0, 4) == 0) ? flaw_e'($urandom_range(1, 3)) : FLAW_NONE;
    case ($urandom_range(0, 9))
      0, 1: send_coded(saspd_pkg::LetAxis, 24, nibs, flaw);
      2, 3: begin
        case ($urandom_range(0, 2))
          0: nibs[3:0] = saspd_pkg::ErrNibCmd;
          1: nibs[3:0] = saspd_pkg::ErrNibFrm;
          default: nibs[3:0] = nibs[3:0];
        endcase
        send_coded(saspd_pkg::LetError, 3, nibs, flaw);
      end
      4: send_coded(saspd_pkg::LetButton, 3, nibs, flaw);
      5: send_coded($urandom_range(0, 1) ? saspd_pkg::LetMode : saspd_pkg::LetNull,
                    1, nibs, flaw);
      6: send_coded($urandom_range(0, 1) ? saspd_pkg::LetRate : saspd_pkg::LetSens,
                    2, nibs, flaw);
      7: begin
        send_byte($urandom_range(0, 1) ? saspd_pkg::LetVer : saspd_pkg::LetZero);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
        send_byte(saspd_pkg::ByteCr);
      end
      8: begin
        // line noise, sometimes closed
        for (k = $urandom_range(1, 6); k != 0; k--) send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) send_byte(saspd_pkg::ByteCr);
      end
      default: begin
        letter = 8'($urandom_range(0, 255));
        send_coded(letter, $urandom_range(0, 5), nibs, FLAW_NONE);
      end
    endcase
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_packet_types();
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    // axes alternate between the two extreme raw values
    send_coded(saspd_pkg::LetAxis, 24, 96'h0000_FFFF_0000_FFFF_0000_FFFF, FLAW_NONE);
    send_coded(saspd_pkg::LetButton, 3, 96'hFFF, FLAW_NONE);
    send_coded(saspd_pkg::LetError, 3, 96'hFF1, FLAW_NONE);
    send_coded(saspd_pkg::LetError, 3, 96'h002, FLAW_NONE);
    send_coded(saspd_pkg::LetError, 3, 96'h00F, FLAW_NONE);
    send_coded(saspd_pkg::LetMode, 1, 96'h5, FLAW_NONE);
    send_coded(saspd_pkg::LetNull, 1, 96'hA, FLAW_NONE);
    send_coded(saspd_pkg::LetRate, 2, 96'h3C, FLAW_NONE);
    send_coded(saspd_pkg::LetSens, 2, 96'hF0, FLAW_NONE);
    // version accepts any payload, zero with none at all
    send_byte(saspd_pkg::LetVer);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(saspd_pkg::ByteCr);
    send_byte(saspd_pkg::LetZero);
    send_byte(saspd_pkg::ByteCr);
    wait_drained();
  endtask

  task automatic test_rejected_packets();
    src_idle_on = 1'b0;
    snk_idle_on = 1'b1;
    // empty packets give nothing
    send_byte(saspd_pkg::ByteCr);
    send_byte(saspd_pkg::ByteCr);
    send_byte(8'h00);
    send_byte(saspd_pkg::ByteCr);
    send_byte(8'hFF);
    send_byte(saspd_pkg::ByteCr);
    send_coded(saspd_pkg::LetMode, 2, 96'h11, FLAW_NONE);
    // lower-case 'a' has the nibble of 'A' but is not its code
    send_byte(saspd_pkg::LetError);
    send_byte(8'h61);
    send_byte(enc(4'h0));
    send_byte(enc(4'h0));
    send_byte(saspd_pkg::ByteCr);
    send_coded(saspd_pkg::LetRate, 1, 96'h7, FLAW_NONE);
    wait_drained();
  endtask

  task automatic test_buffer_overflow();
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    send_byte(saspd_pkg::LetVer);
    repeat (saspd_pkg::BufDepth + 2) send_byte(8'($urandom_range(14, 255)));
    send_byte(saspd_pkg::ByteCr);
    // full buffer then a new packet starts clean
    send_coded(saspd_pkg::LetNull, 1, 96'h9, FLAW_NONE);
    wait_drained();
  endtask

  task automatic test_reports_disabled();
    src_idle_on = 1'b1;
    snk_idle_on = 1'b0;
    write_reg(ReportsEnAddr, 32'd0);
    send_coded(saspd_pkg::LetAxis, 24, {$urandom, $urandom, $urandom}, FLAW_NONE);
    send_coded(saspd_pkg::LetButton, 3, 96'h5A3, FLAW_NONE);
    send_coded(saspd_pkg::LetError, 3, 96'h7C1, FLAW_NONE);
    send_coded(saspd_pkg::LetMode, 1, 96'h2, FLAW_NONE);
    wait_drained();
    // no register behind this address
    write_reg(SpareAddr, 32'hFFFF_FFFF);
    send_coded(saspd_pkg::LetButton, 3, 96'h123, FLAW_NONE);
    wait_drained();
    write_reg(ReportsEnAddr, 32'd1);
    send_coded(saspd_pkg::LetButton, 3, 96'h123, FLAW_NONE);
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    hold_cycles = 300;
    send_coded(saspd_pkg::LetAxis, 24, {$urandom, $urandom, $urandom}, FLAW_NONE);
    send_coded(saspd_pkg::LetError, 3, 96'h3B1, FLAW_NONE);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned phase_end;
    for (phase = 0; phase < 4; phase++) begin
      src_idle_on = (phase != 3) && ($urandom_range(0, 3) != 0);
      snk_idle_on = (phase != 3) && ($urandom_range(0, 3) != 0);
      write_reg(ReportsEnAddr, (phase == 3) ? 32'd1 : 32'($urandom_range(0, 1)));
      phase_end = bytes_sent + PhaseBytes;
      while (bytes_sent < phase_end) send_random_packet();
      // close any open packet so the next phase starts empty
      send_byte(saspd_pkg::ByteCr);
      wait_drained();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    test_packet_types();
    test_rejected_packets();
    test_buffer_overflow();
    test_reports_disabled();
    test_output_backpressure();
    test_random_traffic();
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/saspd_pkg.sv
sv/six_axis_serial_packet_decoder_top.sv
test/six_axis_serial_packet_decoder_top_test.sv
